FILE: sv/tsrb_pkg.sv
// Package for the text scroll region blitter: payload structs, command codes,
// register indexes and geometry defaults. No dependencies.
`timescale 1ns / 1ps
package tsrb_pkg;

   localparam int TextRowsDef     = 24;
   localparam int LinesPerRowDef  = 10;
   localparam int WordsPerLineDef = 64;
   localparam int PlanesDef       = 3;
   localparam int CellBitsDef     = 12;

   typedef enum logic [2:0] {
      FUNC_READ   = 3'd0,
      FUNC_WRITE  = 3'd1,
      FUNC_INSERT = 3'd2,
      FUNC_DELETE = 3'd3,
      FUNC_SCR_UP = 3'd4,
      FUNC_SCR_DN = 3'd5,
      FUNC_RSV6   = 3'd6,
      FUNC_RSV7   = 3'd7
   } func_type;

   localparam logic [2:0] REG_TOP_ROW    = 3'd0;
   localparam logic [2:0] REG_BOTTOM_ROW = 3'd1;
   localparam logic [2:0] REG_FIRST_COL  = 3'd2;
   localparam logic [2:0] REG_LAST_COL   = 3'd3;
   localparam logic [2:0] REG_COLOR_MODE = 3'd4;

   typedef struct packed {
      logic [2:0]  func;
      logic [4:0]  row;
      logic        double_step;
      logic [1:0]  plane;
      logic [13:0] word_addr;
      logic [15:0] wdata;
   } req_type;

   typedef struct packed {
      logic [15:0] rdata;
      logic        done_res;
   } rsp_type;

   // configuration snapshot handed to the back end
   typedef struct packed {
      logic [4:0] top_row;
      logic [4:0] bottom_row;
      logic [6:0] first_col;
      logic [6:0] last_col;
      logic       color_mode;
   } cfg_type;

   // classified command in the queue
   typedef struct packed {
      req_type cmd;
      cfg_type cfg;
   } job_type;

endpackage

FILE: sv/text_scroll_region_blitter.sv
// Top level of the text scroll region blitter: configuration registers,
// front end queue and back end sequencer. Depends on tsrb_pkg, tsrb_front, tsrb_back.
`timescale 1ns / 1ps
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | req_data (req_type)
//  rsp     | out       | rsp_valid / rsp_ready | rsp_data (rsp_type)
//  csr     | in        | csr_valid / csr_ready | csr_index, csr_wdata
//
// Word read or write: the result beat follows the request beat through the queue,
// the RAM port's registered read and the result register.
// Line commands: each covered word steps through word, wait, write and next states, an uncovered
// or out-of-store word through word and next, over lines x words x planes (one plane unless
// colour mode) per moved or cleared row; double step scrolls run twice unless top equals bottom.
// Reset is synchronous; the frame store is not cleared and must be written first.
// A two beat queue parts the front from the sequencer; a held result does not
// block acceptance of beats into the queue while the queue has room.
module text_scroll_region_blitter
   import tsrb_pkg::*;
#(
   parameter int TEXT_ROWS      = TextRowsDef,
   parameter int LINES_PER_ROW  = LinesPerRowDef,
   parameter int WORDS_PER_LINE = WordsPerLineDef,
   parameter int PLANES         = PlanesDef,
   parameter int CELL_BITS      = CellBitsDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [6:0]  csr_wdata
);
   cfg_type cfg_ff, cfg_in;
   logic    job_valid, job_ready;
   job_type job;

   // registers are always writable
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_TOP_ROW:    cfg_in.top_row    = csr_wdata[4:0];
            REG_BOTTOM_ROW: cfg_in.bottom_row = csr_wdata[4:0];
            REG_FIRST_COL:  cfg_in.first_col  = csr_wdata;
            REG_LAST_COL:   cfg_in.last_col   = csr_wdata;
            REG_COLOR_MODE: cfg_in.color_mode = csr_wdata[0];
            default:        cfg_in = cfg_ff; // drop writes beyond the list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{top_row: 5'd0, bottom_row: 5'd23, first_col: 7'd0,
                     last_col: 7'd79, color_mode: 1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tsrb_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_data(req_data), .cfg(cfg_ff), .job_valid(job_valid), .job_ready(job_ready),
      .job(job));

   tsrb_back #(
      .TEXT_ROWS(TEXT_ROWS), .LINES_PER_ROW(LINES_PER_ROW),
      .WORDS_PER_LINE(WORDS_PER_LINE), .PLANES(PLANES), .CELL_BITS(CELL_BITS)
   ) u_back (
      .clock(clock), .reset(reset), .job_valid(job_valid), .job_ready(job_ready),
      .job(job), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data));

   // hold a result that has not been taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped while stalled");
   // unused codes never report completion
   a_rsv_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res == 1'b0 |-> rsp_data.rdata == 16'd0)
      else $error("unused code returned data");
   // queue full holds off the request side
   a_no_accept_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> job_valid)
      else $error("request stalled with empty queue");
endmodule

FILE: sv/tsrb_ram.sv
// Generic single port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module tsrb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

FILE: sv/tsrb_front.sv
// Front end: accept command beats, snapshot the configuration, queue jobs.
// Depends on tsrb_pkg.
`timescale 1ns / 1ps
module tsrb_front
   import tsrb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  cfg_type cfg,
   output logic    job_valid,
   input  logic    job_ready,
   output job_type job
);
   // two entry queue
   job_type    q_ff [2];
   job_type    q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign job_valid = (cnt_ff != 2'd0);
   assign pop       = job_valid && job_ready;
   assign job       = q_ff[0];

   always_comb begin
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         cnt_in  = cnt_in - 2'd1;
      end
      if (push) begin
         q_in[cnt_in[0]] = '{cmd: req_data, cfg: cfg};
         cnt_in          = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
   end
endmodule

FILE: sv/tsrb_back.sv
// Back end: sequence row moves and word accesses over the frame store RAM.
// Depends on tsrb_pkg and tsrb_ram.
`timescale 1ns / 1ps
module tsrb_back
   import tsrb_pkg::*;
#(
   parameter int TEXT_ROWS      = TextRowsDef,
   parameter int LINES_PER_ROW  = LinesPerRowDef,
   parameter int WORDS_PER_LINE = WordsPerLineDef,
   parameter int PLANES         = PlanesDef,
   parameter int CELL_BITS      = CellBitsDef
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   output logic    job_ready,
   input  job_type job,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   localparam int RowWords   = LINES_PER_ROW * WORDS_PER_LINE;
   localparam int PlaneWords = TEXT_ROWS * RowWords;
   localparam int Depth      = PLANES * PlaneWords;
   localparam int AW         = $clog2(Depth);
   localparam int PW         = (PLANES > 1) ? $clog2(PLANES) : 1;
   localparam int LW         = (LINES_PER_ROW > 1) ? $clog2(LINES_PER_ROW) : 1;
   localparam int WW         = $clog2(WORDS_PER_LINE);
   localparam int BW         = (WW + 5 > 12) ? WW + 5 : 12;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_PLAN  = 8'b0000_0010,
      ST_WORD  = 8'b0000_0100,
      ST_RD    = 8'b0000_1000,
      ST_WAIT  = 8'b0001_0000,
      ST_WR    = 8'b0010_0000,
      ST_NEXT  = 8'b0100_0000,
      ST_RESP  = 8'b1000_0000
   } state_type;

   state_type   st_ff, st_in;
   job_type     j_ff, j_in;
   // move plan: cur row walks, ends set by op; clear row after moves
   logic signed [6:0] cur_ff, cur_in, end_ff, end_in, clr_ff, clr_in;
   logic        down_ff, down_in, mv_ff, mv_in, pass2_ff, pass2_in;
   logic [PW-1:0] p_ff, p_in;
   logic [LW-1:0] l_ff, l_in;
   logic [WW-1:0] w_ff, w_in;
   logic [15:0] m_ff, m_in, src_ff, src_in, rd_ff, rd_in;
   rsp_type     out_ff, out_in;
   logic        ov_ff, ov_in;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [15:0]   ram_wd, ram_rd;

   tsrb_ram #(.WIDTH(16), .DEPTH(Depth)) u_ram (
      .clock(clock), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd));

   // column mask of word w
   function automatic logic [15:0] col_mask(input logic [6:0] fc, input logic [6:0] lc,
                                            input logic [WW-1:0] w);
      logic [BW-1:0] fb, lb, lo, hi, a, b;
      logic [16:0]   mh, ml;
      fb = BW'(fc) * BW'(CELL_BITS);
      lb = (BW'(lc) + BW'(1)) * BW'(CELL_BITS);
      lo = BW'(w) << 4;
      hi = lo + BW'(16);
      a  = (fb > lo) ? fb : lo;
      b  = (lb < hi) ? lb : hi;
      mh = (17'd1 << 5'(b - lo)) - 17'd1;
      ml = (17'd1 << 5'(a - lo)) - 17'd1;
      col_mask = (a >= b) ? 16'd0 : mh[15:0] & ~ml[15:0];
   endfunction

   function automatic logic [AW-1:0] waddr(input logic [PW-1:0] p, input logic [6:0] r,
                                           input logic [LW-1:0] l, input logic [WW-1:0] w);
      waddr = AW'(AW'(p) * AW'(PlaneWords) + AW'(r) * AW'(RowWords)
                  + AW'(l) * AW'(WORDS_PER_LINE) + AW'(w));
   endfunction

   logic signed [6:0] top_s, bot_s, row_s, dst_s, src_s;
   logic              mv_src;
   logic              word_ok;
   logic [PW-1:0]     np;
   logic              is_up;

   assign top_s = 7'(signed'({2'b00, j_ff.cfg.top_row}));
   assign bot_s = 7'(signed'({2'b00, j_ff.cfg.bottom_row}));
   assign row_s = 7'(signed'({2'b00, j_ff.cmd.row}));
   assign np    = j_ff.cfg.color_mode ? PW'(PLANES - 1) : '0;
   assign word_ok = (32'(j_ff.cmd.plane) < PLANES) && (32'(j_ff.cmd.word_addr) < PlaneWords);
   assign is_up = (j_ff.cmd.func == FUNC_DELETE) || (j_ff.cmd.func == FUNC_SCR_UP);
   // current destination and source rows
   assign dst_s  = mv_ff ? (down_ff ? cur_ff + 7'sd1 : cur_ff) : clr_ff;
   assign src_s  = down_ff ? cur_ff : cur_ff + 7'sd1;
   assign mv_src = mv_ff;

   assign job_ready = (st_ff == ST_IDLE);
   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      logic signed [6:0] li;
      st_in = st_ff; j_in = j_ff; cur_in = cur_ff; end_in = end_ff; clr_in = clr_ff;
      down_in = down_ff; mv_in = mv_ff; pass2_in = pass2_ff;
      p_in = p_ff; l_in = l_ff; w_in = w_ff; m_in = m_ff; src_in = src_ff; rd_in = rd_ff;
      out_in = out_ff; ov_in = ov_ff;
      ram_we = 1'b0; ram_addr = '0; ram_wd = '0;
      li = 7'sd0;
      if (ov_ff && rsp_ready) begin
         ov_in = 1'b0;
      end
      case (st_ff)
         ST_IDLE: begin
            if (job_valid) begin
               j_in     = job;
               pass2_in = 1'b0;
               rd_in    = '0;
               st_in    = ST_PLAN;
               if (job.cmd.func == FUNC_READ || job.cmd.func == FUNC_WRITE) begin
                  st_in = ST_RD;
               end else if (job.cmd.func == FUNC_RSV6 || job.cmd.func == FUNC_RSV7) begin
                  st_in = ST_RESP;
               end
            end
         end
         ST_PLAN: begin
            // set up one insert, delete or scroll pass
            li = (j_ff.cmd.func == FUNC_INSERT || j_ff.cmd.func == FUNC_DELETE) ? row_s : top_s;
            down_in = !is_up;
            p_in = '0; l_in = '0; w_in = '0;
            if ((j_ff.cmd.func == FUNC_SCR_UP || j_ff.cmd.func == FUNC_SCR_DN)
                && top_s == bot_s) begin
               mv_in = 1'b0; clr_in = bot_s;
               pass2_in = 1'b1;
            end else if (li < top_s || li > bot_s - 7'sd1) begin
               mv_in = 1'b0; clr_in = li;
            end else begin
               mv_in = 1'b1;
               cur_in = is_up ? li : bot_s - 7'sd1;
               end_in = is_up ? bot_s - 7'sd1 : li;
               clr_in = is_up ? bot_s : li;
            end
            st_in = ST_WORD;
         end
         ST_WORD: begin
            m_in = col_mask(j_ff.cfg.first_col, j_ff.cfg.last_col, w_ff);
            if (32'(dst_s) >= TEXT_ROWS ||
                col_mask(j_ff.cfg.first_col, j_ff.cfg.last_col, w_ff) == 16'd0) begin
               st_in = ST_NEXT;
            end else begin
               ram_addr = waddr(p_ff, src_s, l_ff, w_ff);
               st_in    = ST_WAIT;
            end
         end
         ST_WAIT: begin
            src_in   = (mv_src && 32'(src_s) < TEXT_ROWS) ? ram_rd : 16'd0;
            ram_addr = waddr(p_ff, dst_s, l_ff, w_ff);
            st_in    = ST_WR;
         end
         ST_WR: begin
            ram_addr = waddr(p_ff, dst_s, l_ff, w_ff);
            ram_we   = 1'b1;
            ram_wd   = (ram_rd & ~m_ff) | (src_ff & m_ff);
            st_in    = ST_NEXT;
         end
         ST_NEXT: begin
            st_in = ST_WORD;
            if (32'(w_ff) != WORDS_PER_LINE - 1) begin
               w_in = w_ff + WW'(1);
            end else begin
               w_in = '0;
               if (32'(l_ff) != LINES_PER_ROW - 1) begin
                  l_in = l_ff + LW'(1);
               end else begin
                  l_in = '0;
                  if (p_ff != np) begin
                     p_in = p_ff + PW'(1);
                  end else begin
                     p_in = '0;
                     if (mv_ff && cur_ff != end_ff) begin
                        cur_in = down_ff ? cur_ff - 7'sd1 : cur_ff + 7'sd1;
                     end else if (mv_ff) begin
                        mv_in = 1'b0;
                     end else if (!pass2_ff && j_ff.cmd.double_step &&
                                  (j_ff.cmd.func == FUNC_SCR_UP ||
                                   j_ff.cmd.func == FUNC_SCR_DN)) begin
                        pass2_in = 1'b1;
                        st_in    = ST_PLAN;
                     end else begin
                        st_in = ST_RESP;
                     end
                  end
               end
            end
         end
         ST_RD: begin
            // word access: write the word or issue the read address; out of range writes nothing
            ram_addr = AW'(AW'(j_ff.cmd.plane) * AW'(PlaneWords) + AW'(j_ff.cmd.word_addr));
            if (word_ok && j_ff.cmd.func == FUNC_WRITE) begin
               ram_we = 1'b1;
               ram_wd = j_ff.cmd.wdata;
               st_in  = ST_RESP;
            end else begin
               st_in = word_ok ? ST_WAIT : ST_RESP;
            end
            if (word_ok && j_ff.cmd.func == FUNC_READ) begin
               st_in = ST_RESP;
               rd_in = 16'hFFFF; // mark: take RAM data in the result state
            end
         end
         ST_RESP: begin
            // keep the word access address so read data holds while the result waits
            ram_addr = AW'(AW'(j_ff.cmd.plane) * AW'(PlaneWords) + AW'(j_ff.cmd.word_addr));
            if (!ov_ff || rsp_ready) begin
               out_in.rdata    = (j_ff.cmd.func == FUNC_READ && rd_ff != 16'd0) ? ram_rd
                                 : 16'd0;
               out_in.done_res = (j_ff.cmd.func != FUNC_RSV6 && j_ff.cmd.func != FUNC_RSV7);
               ov_in = 1'b1;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
      end
      j_ff <= j_in; cur_ff <= cur_in; end_ff <= end_in; clr_ff <= clr_in;
      down_ff <= down_in; mv_ff <= mv_in; pass2_ff <= pass2_in;
      p_ff <= p_in; l_ff <= l_in; w_ff <= w_in; m_ff <= m_in;
      src_ff <= src_in; rd_ff <= rd_in; out_ff <= out_in;
   end
endmodule

FILE: tb/tb_text_scroll_region_blitter.sv
// Self-checking bench for text_scroll_region_blitter: a clocked driver and monitor
// around an in-bench predictor of the frame store. Depends on tsrb_pkg and the block.
`timescale 1ns / 1ps
module tb_text_scroll_region_blitter;
   import tsrb_pkg::*;

   localparam int ROW_WORDS   = LinesPerRowDef * WordsPerLineDef;
   localparam int PLANE_WORDS = TextRowsDef * ROW_WORDS;
   localparam int CYCLE_LIMIT = 20000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = REG_TOP_ROW;
   logic [6:0]  csr_wdata = '0;

   text_scroll_region_blitter dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state: own copy of the planes and the live register values
   logic [15:0] plane_mem [0:PlanesDef*PLANE_WORDS-1];
   logic [4:0]  win_top, win_bottom;
   logic [6:0]  win_first, win_last;
   logic        colour_on;

   req_type     pending_beats [$];
   rsp_type     expected_rsp [$];
   int          errors = 0;
   int          cycles = 0;

   // words the host wrote whole (plane * PLANE_WORDS + address); in-range reads pick only these
   int          written_words [$];

   task automatic report(input string what);
      $display("mismatch at cycle %0d: %s", cycles, what);
      errors++;
   endtask

   // bits of the column window that land in word w of a scan line
   function automatic logic [15:0] window_mask(input int w);
      int fbit, lbit, lo, a, b;
      logic [31:0] m;
      fbit = win_first * CellBitsDef;
      lbit = (win_last + 1) * CellBitsDef;
      lo   = w * 16;
      a    = (fbit > lo) ? fbit : lo;
      b    = (lbit < lo + 16) ? lbit : lo + 16;
      if (a >= b) return '0;
      m = ((32'd1 << (b - lo)) - 1) & ~((32'd1 << (a - lo)) - 1);
      return m[15:0];
   endfunction

   // copy text row src onto dst under the window; src < 0 clears
   task automatic shift_row(input int dst, input int src);
      int planes, idx;
      logic [15:0] m, v;
      planes = colour_on ? PlanesDef : 1;
      for (int p = 0; p < planes; p++)
         for (int ln = 0; ln < LinesPerRowDef; ln++)
            for (int w = 0; w < WordsPerLineDef; w++) begin
               m = window_mask(w);
               if (m == 0) continue;
               v = '0;
               if (src >= 0 && src < TextRowsDef)
                  v = plane_mem[p*PLANE_WORDS + src*ROW_WORDS + ln*WordsPerLineDef + w];
               if (dst < TextRowsDef) begin
                  idx = p*PLANE_WORDS + dst*ROW_WORDS + ln*WordsPerLineDef + w;
                  plane_mem[idx] = (plane_mem[idx] & ~m) | (v & m);
               end
            end
   endtask

   task automatic open_line(input int r);
      if (r < win_top || r > int'(win_bottom) - 1) begin
         shift_row(r, -1);
         return;
      end
      for (int cx = int'(win_bottom) - 1; cx >= r; cx--) shift_row(cx + 1, cx);
      shift_row(r, -1);
   endtask

   task automatic close_line(input int r);
      if (r < win_top || r > int'(win_bottom) - 1) begin
         shift_row(r, -1);
         return;
      end
      for (int cx = r; cx < win_bottom; cx++) shift_row(cx, cx + 1);
      shift_row(win_bottom, -1);
   endtask

   // apply one command to the predicted store and return the answer it earns
   task automatic blit_predict(input req_type c, output rsp_type r);
      logic in_range;
      in_range = (c.plane < PlanesDef) && (c.word_addr < PLANE_WORDS);
      r = '{rdata: 16'h0, done_res: 1'b1};
      case (func_type'(c.func))
         FUNC_READ:  if (in_range) r.rdata = plane_mem[c.plane*PLANE_WORDS + c.word_addr];
         FUNC_WRITE: if (in_range) plane_mem[c.plane*PLANE_WORDS + c.word_addr] = c.wdata;
         FUNC_INSERT: open_line(c.row);
         FUNC_DELETE: close_line(c.row);
         FUNC_SCR_UP, FUNC_SCR_DN: begin
            if (win_top == win_bottom) shift_row(win_bottom, -1);
            else if (func_type'(c.func) == FUNC_SCR_UP) begin
               close_line(win_top);
               if (c.double_step) close_line(win_top);
            end else begin
               open_line(win_top);
               if (c.double_step) open_line(win_top);
            end
         end
         default: r.done_res = 1'b0;
      endcase
   endtask

   // driver: bursts of beats with random gaps; hold the beat until taken
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready) begin
         // hold
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left--;
      end else if (pending_beats.size() > 0) begin
         req_data  <= pending_beats.pop_front();
         req_valid <= 1'b1;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
         end else begin
            burst_left--;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver: switch stall style periodically, some stretches always ready
   int stall_style = 0;
   logic [15:0] stall_pattern = 16'hFFFF;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles % 256 == 0) begin
         stall_style   = $urandom_range(0, 2);
         stall_pattern = 16'($urandom);
      end
      if (reset) rsp_ready <= 1'b0;
      else case (stall_style)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: begin
            rsp_ready     <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
         end
      endcase
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // monitor: compare results against the oldest prediction, then predict new beats
   always @(posedge clock) begin
      rsp_type predicted;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               report("result beat with nothing outstanding");
            end else begin
               predicted = expected_rsp.pop_front();
               if (rsp_data.rdata !== predicted.rdata)
                  report($sformatf("rdata %h, want %h", rsp_data.rdata, predicted.rdata));
               if (rsp_data.done_res !== predicted.done_res)
                  report($sformatf("done_res %b, want %b",
                                   rsp_data.done_res, predicted.done_res));
            end
         end
         if (req_valid && req_ready) begin
            blit_predict(req_data, predicted);
            expected_rsp.push_back(predicted);
         end
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [6:0] val);
      @(posedge clock);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_TOP_ROW:    win_top    = val[4:0];
         REG_BOTTOM_ROW: win_bottom = val[4:0];
         REG_FIRST_COL:  win_first  = val;
         REG_LAST_COL:   win_last   = val;
         default:        colour_on  = val[0];
      endcase
      csr_valid <= 1'b0;
   endtask

   // wait until every beat has gone in and every answer has come back
   task automatic drain();
      while (pending_beats.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_window(input int t, input int b, input int f, input int l, input int c);
      write_reg(REG_TOP_ROW, 7'(t));
      write_reg(REG_BOTTOM_ROW, 7'(b));
      write_reg(REG_FIRST_COL, 7'(f));
      write_reg(REG_LAST_COL, 7'(l));
      write_reg(REG_COLOR_MODE, 7'(c));
   endtask

   function automatic req_type make_beat(input func_type f, input int r, input int p,
                                         input int a, input int d, input int ds);
      req_type b;
      b.func        = f;
      b.row         = 5'(r);
      b.double_step = 1'(ds);
      b.plane       = 2'(p);
      b.word_addr   = 14'(a);
      b.wdata       = 16'(d);
      return b;
   endfunction

   // whole-word write inside the store; remember it as readable
   task automatic push_write(input int p, input int a, input int d);
      pending_beats.push_back(make_beat(FUNC_WRITE, 0, p, a, d, 0));
      written_words.push_back(p * PLANE_WORDS + a);
   endtask

   // clear the window words of rows lo..hi so that row moves read only written words
   task automatic prime_rows(input int lo, input int hi, input int f, input int l,
                             input int c);
      set_window(31, 31, f, l, c);
      for (int r = lo; r <= hi && r < TextRowsDef; r++)
         pending_beats.push_back(make_beat(FUNC_INSERT, r, 0, 0, 0, 0));
      drain();
   endtask

   // writes land in rows lo_row..hi_row; in-range reads pick a word that the host wrote
   function automatic req_type random_beat(input int lo_row, input int hi_row);
      int pick, p, a;
      pick = $urandom_range(0, 9);
      if (pick < 3 && written_words.size() > 0) begin
         a = written_words[$urandom_range(0, written_words.size() - 1)];
         return make_beat(FUNC_READ, $urandom_range(0, 31), a / PLANE_WORDS,
                          a % PLANE_WORDS, $urandom, $urandom_range(0, 1));
      end
      if (pick < 5) begin
         p = $urandom_range(0, 2);
         a = $urandom_range(lo_row, hi_row) * ROW_WORDS + $urandom_range(0, ROW_WORDS - 1);
         written_words.push_back(p * PLANE_WORDS + a);
         return make_beat(FUNC_WRITE, $urandom_range(0, 31), p, a, $urandom,
                          $urandom_range(0, 1));
      end
      if (pick < 9)
         return make_beat(func_type'(FUNC_INSERT + $urandom_range(0, 3)),
                          $urandom_range(0, 31), $urandom_range(0, 3),
                          $urandom_range(0, 16383), $urandom, $urandom_range(0, 1));
      // noise: out-of-range accesses and unused codes
      return make_beat(func_type'($urandom_range(0, 1) ? $urandom_range(6, 7)
                                                         : $urandom_range(0, 1)),
                       $urandom_range(0, 31), 3, $urandom_range(0, 16383), $urandom,
                       $urandom_range(0, 1));
   endfunction

   initial begin
      int t, b, f, l;
      int c, lo, hi, wlo, whi;
      win_top = 0; win_bottom = 23; win_first = 0; win_last = 79; colour_on = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, every command, the named corner cases
      prime_rows(1, 4, 3, 40, 1);
      set_window(1, 4, 3, 40, 1);
      push_write(0, 0, 16'hFFFF);
      push_write(2, PLANE_WORDS - 1, 16'h0000);
      push_write(1, 2*ROW_WORDS + 5, 16'h5A5A);
      pending_beats.push_back(make_beat(FUNC_READ, 0, 0, 0, 0, 0));
      pending_beats.push_back(make_beat(FUNC_READ, 0, 2, PLANE_WORDS - 1, 0, 0));
      pending_beats.push_back(make_beat(FUNC_WRITE, 0, 3, 100, 16'h1234, 0));
      pending_beats.push_back(make_beat(FUNC_READ, 0, 3, 100, 0, 0));
      pending_beats.push_back(make_beat(FUNC_WRITE, 0, 1, 16383, 16'hABCD, 0));
      pending_beats.push_back(make_beat(FUNC_READ, 31, 1, 16383, 0, 1));
      pending_beats.push_back(make_beat(FUNC_RSV6, 0, 0, 0, 0, 0));
      pending_beats.push_back(make_beat(FUNC_RSV7, 31, 3, 16383, 16'hFFFF, 1));
      pending_beats.push_back(make_beat(FUNC_INSERT, 2, 0, 0, 0, 0));
      pending_beats.push_back(make_beat(FUNC_DELETE, 1, 0, 0, 0, 0));
      pending_beats.push_back(make_beat(FUNC_INSERT, 4, 0, 0, 0, 0));
      pending_beats.push_back(make_beat(FUNC_DELETE, 0, 0, 0, 0, 0));
      pending_beats.push_back(make_beat(FUNC_SCR_UP, 0, 0, 0, 0, 0));
      pending_beats.push_back(make_beat(FUNC_SCR_DN, 0, 0, 0, 0, 1));
      pending_beats.push_back(make_beat(FUNC_READ, 0, 1, 2*ROW_WORDS + 5, 0, 0));
      drain();
      // reversed columns, then a window past the end of the line, then one within one word
      set_window(0, 3, 50, 10, 0);
      pending_beats.push_back(make_beat(FUNC_SCR_UP, 0, 0, 0, 0, 1));
      drain();
      prime_rows(20, 31, 75, 127, 1);
      set_window(20, 31, 75, 127, 1);
      pending_beats.push_back(make_beat(FUNC_SCR_DN, 0, 0, 0, 0, 1));
      pending_beats.push_back(make_beat(FUNC_DELETE, 30, 0, 0, 0, 0));
      drain();
      set_window(22, 22, 4, 4, 0);
      push_write(0, 22*ROW_WORDS + 3, 16'hC3C3);
      pending_beats.push_back(make_beat(FUNC_SCR_UP, 0, 0, 0, 0, 0));
      pending_beats.push_back(make_beat(FUNC_READ, 0, 0, 22*ROW_WORDS + 3, 0, 0));
      drain();
      // reversed region: every line command only clears
      set_window(31, 0, 0, 127, 0);
      pending_beats.push_back(make_beat(FUNC_INSERT, 0, 0, 0, 0, 0));
      pending_beats.push_back(make_beat(FUNC_SCR_DN, 0, 0, 0, 0, 1));
      drain();

      // random phases; region rows inside the store are cleared first
      for (int ph = 0; ph < 6; ph++) begin
         if ($urandom_range(0, 1)) begin
            t = $urandom_range(0, 5);
            b = t + $urandom_range(0, 2);
            if (b > 5) b = 5;
         end else begin
            t = $urandom_range(20, 31);
            b = t + $urandom_range(0, 2);
            if (b > 31) b = 31;
         end
         if ($urandom_range(0, 5) == 0) begin
            int tmp;
            tmp = t; t = b; b = tmp - 1;
            if (b < 0) b = 0;
         end
         case ($urandom_range(0, 3))
            0: begin f = 0; l = 79; end
            1: begin f = $urandom_range(0, 79); l = $urandom_range(f, 79); end
            2: begin f = $urandom_range(0, 127); l = $urandom_range(0, 127); end
            default: begin f = $urandom_range(0, 79); l = f; end
         endcase
         c  = ($urandom_range(0, 9) < 3);
         lo = (t < b) ? t : b;
         hi = (t < b) ? b : t;
         prime_rows(lo, hi, f, l, c);
         set_window(t, b, f, l, c);
         wlo = (lo < TextRowsDef) ? lo : 0;
         whi = (hi < TextRowsDef) ? hi : TextRowsDef - 1;
         repeat (10) pending_beats.push_back(random_beat(wlo, whi));
         drain();
      end

      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
